>>> hdl/sfla_pkg.sv
// sfla_pkg: shared types, codes and field widths of the slot free list allocator
// no dependencies
package sfla_pkg;

	localparam int OP_W     = 2;
	localparam int SLOT_W   = 10;
	localparam int COUNT_W  = 11;
	localparam int STATUS_W = 2;

	localparam int MAX_SLOTS_DEFAULT = 1024;
	localparam logic [COUNT_W-1:0] POOL_SLOTS_RESET = 11'd1024;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_REBUILD = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_RANGE  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_INIT,
		FSM_IDLE,
		FSM_ALLOC,
		FSM_REBUILD
	} fsm_t;

endpackage

>>> hdl/sfla_req_if.sv
// sfla_req_if: request channel of the allocator, valid/ready plus item fields
// depends on sfla_pkg
interface sfla_req_if
	import sfla_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [SLOT_W-1:0]   slot_in;

	modport source (output valid, output operation, output slot_in, input ready);
	modport sink (input valid, input operation, input slot_in, output ready);
endinterface

>>> hdl/sfla_rsp_if.sv
// sfla_rsp_if: result channel of the allocator, valid/ready plus item fields
// depends on sfla_pkg
interface sfla_rsp_if
	import sfla_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot_out;
	logic [COUNT_W-1:0]  free_count;

	modport source (output valid, output status, output slot_out, output free_count,
		input ready);
	modport sink (input valid, input status, input slot_out, input free_count,
		output ready);
endinterface

>>> hdl/sfla_ram.sv
// sfla_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module sfla_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/slot_free_list_allocator.sv
// slot_free_list_allocator: pool allocator with a linked free list in a link ram
// depends on sfla_pkg, sfla_req_if, sfla_rsp_if, sfla_ram
//
// After reset the block runs an init pass that links every slot to the next one;
// req.ready stays low during it, pool size writes are taken as ever.
// Then a successful allocate reads the head entry from the link ram and updates the list in
// FSM_ALLOC, while a failed allocate, a free or an unknown operation loads its result in the
// cycle it is taken. A rebuild relinks the slots of the effective pool size one by one,
// since each relink is one write on the single link ram write port. One item is in work
// at a time; a new item is taken while the previous result waits, as long as the result
// register drains in that cycle.
module slot_free_list_allocator
	import sfla_pkg::*;
#(
	parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [COUNT_W-1:0] cfg_data,
	sfla_req_if.sink           req,
	sfla_rsp_if.source         rsp
);

	localparam int AW = $clog2(MAX_SLOTS);
	localparam int LW = $clog2(MAX_SLOTS + 1);
	localparam int NW = (LW > COUNT_W) ? LW : COUNT_W;
	localparam logic [NW-1:0] MAX_N = NW'(MAX_SLOTS);
	localparam logic [LW-1:0] LAST_IDX = LW'(MAX_SLOTS - 1);
	localparam logic [COUNT_W-1:0] FREE_RESET =
		COUNT_W'((int'(POOL_SLOTS_RESET) > MAX_SLOTS) ? MAX_SLOTS : int'(POOL_SLOTS_RESET));

	fsm_t                state_q, state_d;
	logic [COUNT_W-1:0]  pool_q;
	logic [COUNT_W-1:0]  head_q, head_d;
	logic [COUNT_W-1:0]  free_q, free_d;
	logic                empty_q, empty_d;
	logic [LW-1:0]       walk_q, walk_d;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_out_q;
	logic [COUNT_W-1:0]  count_q;

	logic                load_out;
	status_t             nstatus;
	logic [SLOT_W-1:0]   nslot;
	logic [COUNT_W-1:0]  ncount;

	logic                we;
	logic [AW-1:0]       waddr;
	logic [LW-1:0]       wdata;
	logic [AW-1:0]       raddr;
	logic [LW-1:0]       rdata;

	logic [NW-1:0]       pool_ext, n_w, head_ext, free_ext, slot_ext, rdata_ext, link_ext;
	logic [NW-1:0]       walk_next_ext;
	logic [LW-1:0]       walk_next;
	logic                out_free, accept;
	op_t                 op;

	assign pool_ext      = NW'(pool_q);
	assign n_w           = (pool_ext == '0) ? NW'(1) : ((pool_ext > MAX_N) ? MAX_N : pool_ext);
	assign head_ext      = NW'(head_q);
	assign free_ext      = NW'(free_q);
	assign slot_ext      = NW'(req.slot_in);
	assign rdata_ext     = NW'(rdata);
	assign link_ext      = empty_q ? n_w : head_ext;
	assign walk_next     = walk_q + LW'(1);
	assign walk_next_ext = NW'(walk_next);
	assign out_free      = !out_valid_q || rsp.ready;
	assign op            = op_t'(req.operation);
	assign accept        = req.valid && req.ready;

	sfla_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_SLOTS)
	) u_link_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		free_d    = free_q;
		empty_d   = empty_q;
		walk_d    = walk_q;
		load_out  = 1'b0;
		nstatus   = ST_OK;
		nslot     = '0;
		ncount    = free_q;
		we        = 1'b0;
		waddr     = walk_q[AW-1:0];
		wdata     = walk_next;
		raddr     = head_ext[AW-1:0];
		req.ready = 1'b0;
		case (state_q)
			FSM_INIT: begin
				we = 1'b1;
				if (walk_q == LAST_IDX) begin
					walk_d  = '0;
					state_d = FSM_IDLE;
				end else begin
					walk_d = walk_next;
				end
			end
			FSM_IDLE: begin
				req.ready = out_free;
				if (accept) begin
					case (op)
						OP_ALLOC: begin
							if (free_q == '0 || empty_q || head_ext >= n_w) begin
								load_out = 1'b1;
								nstatus  = ST_EMPTY;
							end else begin
								free_d  = free_q - COUNT_W'(1);
								state_d = FSM_ALLOC;
							end
						end
						OP_FREE: begin
							if (slot_ext >= n_w) begin
								load_out = 1'b1;
								nstatus  = ST_RANGE;
							end else if (free_ext >= n_w) begin
								load_out = 1'b1;
								nstatus  = ST_FULL;
							end else begin
								we       = 1'b1;
								waddr    = slot_ext[AW-1:0];
								wdata    = link_ext[LW-1:0];
								head_d   = slot_ext[COUNT_W-1:0];
								empty_d  = 1'b0;
								free_d   = free_q + COUNT_W'(1);
								load_out = 1'b1;
								ncount   = free_q + COUNT_W'(1);
							end
						end
						OP_REBUILD: begin
							walk_d  = '0;
							state_d = FSM_REBUILD;
						end
						default: begin
							load_out = 1'b1;
						end
					endcase
				end
			end
			FSM_ALLOC: begin
				load_out = 1'b1;
				nslot    = head_q[SLOT_W-1:0];
				if (free_q != '0) begin
					head_d = rdata_ext[COUNT_W-1:0];
				end else begin
					empty_d = 1'b1;
				end
				state_d = FSM_IDLE;
			end
			FSM_REBUILD: begin
				we = 1'b1;
				if (walk_next_ext == n_w) begin
					head_d   = '0;
					free_d   = n_w[COUNT_W-1:0];
					empty_d  = 1'b0;
					walk_d   = '0;
					load_out = 1'b1;
					ncount   = n_w[COUNT_W-1:0];
					state_d  = FSM_IDLE;
				end else begin
					walk_d = walk_next;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_INIT;
			pool_q      <= POOL_SLOTS_RESET;
			head_q      <= '0;
			free_q      <= FREE_RESET;
			empty_q     <= 1'b0;
			walk_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			free_q  <= free_d;
			empty_q <= empty_d;
			walk_q  <= walk_d;
			if (cfg_write) begin
				pool_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q   <= nstatus;
			slot_out_q <= nslot;
			count_q    <= ncount;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.slot_out   = slot_out_q;
	assign rsp.free_count = count_q;

	a_init_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_INIT |-> !req.ready)
		else $error("item taken during init pass");

	a_alloc_seq: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_ALLOC && free_q != '0 && !empty_q && head_ext < n_w
		|=> state_q == FSM_ALLOC)
		else $error("allocate did not wait for link read");

	a_alloc_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_ALLOC |=> rsp.valid)
		else $error("allocate result missing");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> out_free)
		else $error("result register overwritten");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> free_q == '0)
		else $error("empty list with nonzero count");

endmodule
